// File: design/ibde_pkg.sv
// ----------------------------------------------------------------------------
// ibde_pkg
// Shared types and constants of the indexed raster draw and blit engine.
// ----------------------------------------------------------------------------
package ibde_pkg;

   localparam int MAX_FRAME_W = 256;
   localparam int MAX_FRAME_H = 256;
   localparam int COL_BITS    = $clog2(MAX_FRAME_W);
   localparam int ROW_BITS    = $clog2(MAX_FRAME_H);
   localparam int ADDR_W      = COL_BITS + ROW_BITS;
   localparam int STORE_DEPTH = MAX_FRAME_W * MAX_FRAME_H;
   localparam int DIM_W       = 9;
   localparam int POS_W       = 10;
   localparam int CRD_W       = 12;
   localparam int PIX_W       = 8;
   localparam int RAMP_BITS   = 3;

   typedef enum logic [2:0] {
      FUNC_WRITE   = 3'd0,
      FUNC_READ    = 3'd1,
      FUNC_FILL    = 3'd2,
      FUNC_OUTLINE = 3'd3,
      FUNC_SWAP    = 3'd4,
      FUNC_RAMP    = 3'd5,
      FUNC_LOAD    = 3'd6,
      FUNC_BLIT    = 3'd7
   } func_type;

   localparam logic [1:0] CSR_FRAME_W  = 2'd0;
   localparam logic [1:0] CSR_FRAME_H  = 2'd1;
   localparam logic [1:0] CSR_SOURCE_W = 2'd2;
   localparam logic [1:0] CSR_SOURCE_H = 2'd3;

   typedef struct packed {
      logic ready;
      logic clear;
      logic seg_init;
      logic seg_inc;
      logic loop_init;
      logic calc;
      logic wr;
   } dp_cmd_type;

   typedef struct packed {
      func_type func;
      logic     clear_last;
      logic     loop_empty;
      logic     loop_last;
      logic     seg_last;
      logic     rsp_busy;
   } dp_status_type;

endpackage

// File: design/indexed_raster_draw_blit_engine_top.sv
// ----------------------------------------------------------------------------
// indexed_raster_draw_blit_engine_top
// 2D draw and blit command engine over an 8-bit indexed frame and source store.
// ----------------------------------------------------------------------------
// Steps: each pixel takes a calc step, then a write step; read, swap, ramp
//   and blit put a store read step between them, set by the single shared
//   port of each store (read, then write).
// Write, read and load act on one pixel; one command is taken at a time.
// Reset: synchronous; clearing zeroes all 65536 entries of both stores,
//   one entry per cycle, while no command is taken (csr writes still apply).
module indexed_raster_draw_blit_engine_top import ibde_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [2:0]              req_func,
   input  logic signed [POS_W-1:0] req_pos_x,
   input  logic signed [POS_W-1:0] req_pos_y,
   input  logic [DIM_W-1:0]        req_rect_w,
   input  logic [DIM_W-1:0]        req_rect_h,
   input  logic [PIX_W-1:0]        req_color_a,
   input  logic [PIX_W-1:0]        req_color_b,
   input  logic [PIX_W-1:0]        req_color_c,
   input  logic signed [POS_W-1:0] req_src_x,
   input  logic signed [POS_W-1:0] req_src_y,
   input  logic [2:0]              req_blit_flags,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [PIX_W-1:0]        rsp_pixel_value,
   input  logic                    csr_write_enable,
   input  logic [1:0]              csr_index,
   input  logic [DIM_W-1:0]        csr_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // take a transfer only when the sequencer sits idle
   assign req_stall = !cmd.ready;

   ibde_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .cmd       (cmd)
   );

   // the result register parts the output channel from the pixel loop
   ibde_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_valid        (req_valid),
      .req_func         (req_func),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_rect_w       (req_rect_w),
      .req_rect_h       (req_rect_h),
      .req_color_a      (req_color_a),
      .req_color_b      (req_color_b),
      .req_color_c      (req_color_c),
      .req_src_x        (req_src_x),
      .req_src_y        (req_src_y),
      .req_blit_flags   (req_blit_flags),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_value  (rsp_pixel_value)
   );

endmodule

// File: design/ibde_ram.sv
// ----------------------------------------------------------------------------
// ibde_ram
// Single-port RAM, one address for read and write, registered read data.
// ----------------------------------------------------------------------------
module ibde_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// File: design/ibde_ctrl.sv
// ----------------------------------------------------------------------------
// ibde_ctrl
// Command sequencer: clearing pass, segment and pixel loop control.
// ----------------------------------------------------------------------------
module ibde_ctrl import ibde_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_START, ST_CALC, ST_RD, ST_WR, ST_SEGEND
   } state_type;

   state_type state_ff, state_in;
   logic      needs_read;

   always_comb begin
      needs_read = (status.func == FUNC_READ) || (status.func == FUNC_SWAP) ||
                   (status.func == FUNC_RAMP) || (status.func == FUNC_BLIT);
   end

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            cmd.ready    = 1'b1;
            cmd.seg_init = 1'b1;
            if (req_valid) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            cmd.loop_init = 1'b1;
            state_in = status.loop_empty ? ST_SEGEND : ST_CALC;
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = needs_read ? ST_RD : ST_WR;
         end
         ST_RD: begin
            state_in = ST_WR;
         end
         ST_WR: begin
            // hold while the previous read result waits
            if (!(status.func == FUNC_READ && status.rsp_busy)) begin
               cmd.wr   = 1'b1;
               state_in = status.loop_last ? ST_SEGEND : ST_CALC;
            end
         end
         ST_SEGEND: begin
            if (status.seg_last) begin
               state_in = ST_IDLE;
            end else begin
               cmd.seg_inc = 1'b1;
               state_in    = ST_START;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: design/ibde_dp.sv
// ----------------------------------------------------------------------------
// ibde_dp
// Datapath: command and size registers, loop counters, coordinate and clip
// logic, both pixel stores and the result register.
// ----------------------------------------------------------------------------
module ibde_dp import ibde_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  dp_cmd_type              cmd,
   output dp_status_type           status,
   input  logic                    req_valid,
   input  logic [2:0]              req_func,
   input  logic signed [POS_W-1:0] req_pos_x,
   input  logic signed [POS_W-1:0] req_pos_y,
   input  logic [DIM_W-1:0]        req_rect_w,
   input  logic [DIM_W-1:0]        req_rect_h,
   input  logic [PIX_W-1:0]        req_color_a,
   input  logic [PIX_W-1:0]        req_color_b,
   input  logic [PIX_W-1:0]        req_color_c,
   input  logic signed [POS_W-1:0] req_src_x,
   input  logic signed [POS_W-1:0] req_src_y,
   input  logic [2:0]              req_blit_flags,
   input  logic                    csr_write_enable,
   input  logic [1:0]              csr_index,
   input  logic [DIM_W-1:0]        csr_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [PIX_W-1:0]        rsp_pixel_value
);

   func_type                func_ff;
   logic signed [CRD_W-1:0] px_ff, py_ff, sx_ff, sy_ff;
   logic [DIM_W-1:0]        w_ff, h_ff;
   logic [PIX_W-1:0]        ca_ff, cb_ff, cc_ff;
   logic [2:0]              flags_ff;
   logic [DIM_W-1:0]        fw_ff, fh_ff, sw_ff, sh_ff;
   logic [1:0]              seg_ff;
   logic [DIM_W-1:0]        i_ff, j_ff;
   logic [ADDR_W-1:0]       clr_ff;
   logic [ADDR_W-1:0]       faddr_ff, saddr_ff;
   logic                    fok_ff, sok_ff;
   logic                    rsp_valid_ff;
   logic [PIX_W-1:0]        rsp_pixel_ff;

   logic [DIM_W-1:0]        fw_eff, fh_eff, sw_eff, sh_eff;
   logic signed [CRD_W-1:0] bx, by, dx, dy, csx, csy, i12, j12, w12, h12;
   logic                    vert;
   logic [DIM_W-1:0]        ni, nj;
   logic                    fok, sok, accept;
   logic [PIX_W-1:0]        f_rd, sdata, f_wd, ramp_base, ramp_val;
   logic                    f_we, s_we, rsp_load;
   logic                    fram_we, sram_we;
   logic [ADDR_W-1:0]       fram_addr, sram_addr;
   logic [PIX_W-1:0]        fram_wd, sram_wd;

   localparam logic [DIM_W-1:0] MAX_W = DIM_W'(MAX_FRAME_W);
   localparam logic [DIM_W-1:0] MAX_H = DIM_W'(MAX_FRAME_H);

   assign accept = req_valid && cmd.ready;

   // saturate dimension registers to the store size
   assign fw_eff = (fw_ff > MAX_W) ? MAX_W : fw_ff;
   assign fh_eff = (fh_ff > MAX_H) ? MAX_H : fh_ff;
   assign sw_eff = (sw_ff > MAX_W) ? MAX_W : sw_ff;
   assign sh_eff = (sh_ff > MAX_H) ? MAX_H : sh_ff;

   assign i12 = signed'({3'b000, i_ff});
   assign j12 = signed'({3'b000, j_ff});
   assign w12 = signed'({3'b000, w_ff});
   assign h12 = signed'({3'b000, h_ff});

   // segment geometry
   always_comb begin
      bx   = px_ff;
      by   = py_ff;
      vert = 1'b0;
      ni   = DIM_W'(1);
      nj   = DIM_W'(1);
      case (func_ff)
         FUNC_SWAP, FUNC_RAMP: begin
            bx = '0;
            by = '0;
            ni = fw_eff;
            nj = fh_eff;
         end
         FUNC_FILL, FUNC_BLIT: begin
            ni = w_ff;
            nj = h_ff;
         end
         FUNC_OUTLINE: begin
            case (seg_ff)
               2'd0: ni = w_ff;
               2'd1: begin
                  ni = w_ff;
                  by = py_ff + h12 - CRD_W'(1);
               end
               2'd2: begin
                  ni   = h_ff;
                  vert = 1'b1;
               end
               default: begin
                  ni   = h_ff;
                  vert = 1'b1;
                  bx   = px_ff + w12 - CRD_W'(1);
               end
            endcase
         end
         default: ;
      endcase
   end

   // destination and source coordinates of the current pixel
   always_comb begin
      dx = bx + (vert ? CRD_W'(0) : i12);
      dy = by + (vert ? i12 : j12);
      if (func_ff == FUNC_BLIT) begin
         csx = flags_ff[2] ? (sx_ff + w12 - CRD_W'(1) - i12) : (sx_ff + i12);
         csy = flags_ff[1] ? (sy_ff + h12 - CRD_W'(1) - j12) : (sy_ff + j12);
      end else begin
         csx = sx_ff;
         csy = sy_ff;
      end
      fok = !dx[CRD_W-1] && !dy[CRD_W-1] &&
            (unsigned'(dx) < {3'b000, fw_eff}) && (unsigned'(dy) < {3'b000, fh_eff});
      sok = !csx[CRD_W-1] && !csy[CRD_W-1] &&
            (unsigned'(csx) < {3'b000, sw_eff}) && (unsigned'(csy) < {3'b000, sh_eff});
   end

   ibde_ram #(.WIDTH(PIX_W), .DEPTH(STORE_DEPTH)) u_frame (
      .clock (clock),
      .we    (fram_we),
      .addr  (fram_addr),
      .wdata (fram_wd),
      .rdata (f_rd)
   );
   ibde_ram #(.WIDTH(PIX_W), .DEPTH(STORE_DEPTH)) u_source (
      .clock (clock),
      .we    (sram_we),
      .addr  (sram_addr),
      .wdata (sram_wd),
      .rdata (sdata)
   );

   // ramp recolor value
   always_comb begin
      if (f_rd < cb_ff) begin
         ramp_base = ca_ff;
      end else if (f_rd < cc_ff) begin
         ramp_base = cb_ff;
      end else begin
         ramp_base = cc_ff;
      end
      ramp_val = {{(PIX_W-RAMP_BITS){1'b0}}, f_rd[RAMP_BITS-1:0]} + ramp_base;
   end

   // write decision for the current pixel
   always_comb begin
      f_we     = 1'b0;
      s_we     = 1'b0;
      rsp_load = 1'b0;
      f_wd     = ca_ff;
      case (func_ff)
         FUNC_WRITE, FUNC_FILL, FUNC_OUTLINE: f_we = fok_ff;
         FUNC_READ: rsp_load = 1'b1;
         FUNC_SWAP: begin
            f_we = fok_ff && (f_rd == ca_ff);
            f_wd = cb_ff;
         end
         FUNC_RAMP: begin
            f_we = fok_ff && (f_rd != '0);
            f_wd = ramp_val;
         end
         FUNC_LOAD: s_we = sok_ff;
         default: begin
            f_we = fok_ff && sok_ff && !(flags_ff[0] && (sdata == '0));
            f_wd = sdata;
         end
      endcase
   end

   assign fram_we   = cmd.clear || (cmd.wr && f_we);
   assign sram_we   = cmd.clear || (cmd.wr && s_we);
   assign fram_addr = cmd.clear ? clr_ff : faddr_ff;
   assign sram_addr = cmd.clear ? clr_ff : saddr_ff;
   assign fram_wd   = cmd.clear ? '0 : f_wd;
   assign sram_wd   = cmd.clear ? '0 : ca_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff        <= MAX_W;
         fh_ff        <= MAX_H;
         sw_ff        <= MAX_W;
         sh_ff        <= MAX_H;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_FRAME_W:  fw_ff <= csr_data;
               CSR_FRAME_H:  fh_ff <= csr_data;
               CSR_SOURCE_W: sw_ff <= csr_data;
               CSR_SOURCE_H: sh_ff <= csr_data;
               default: ;
            endcase
         end
         if (cmd.clear) begin
            clr_ff <= clr_ff + ADDR_W'(1);
         end
         if (cmd.wr && rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload and loop registers
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff  <= func_type'(req_func);
         px_ff    <= CRD_W'(req_pos_x);
         py_ff    <= CRD_W'(req_pos_y);
         sx_ff    <= CRD_W'(req_src_x);
         sy_ff    <= CRD_W'(req_src_y);
         w_ff     <= req_rect_w;
         h_ff     <= req_rect_h;
         ca_ff    <= req_color_a;
         cb_ff    <= req_color_b;
         cc_ff    <= req_color_c;
         flags_ff <= req_blit_flags;
      end
      if (cmd.seg_init) begin
         seg_ff <= '0;
      end else if (cmd.seg_inc) begin
         seg_ff <= seg_ff + 2'd1;
      end
      if (cmd.loop_init) begin
         i_ff <= '0;
         j_ff <= '0;
      end else if (cmd.wr) begin
         if ({1'b0, i_ff} + 10'd1 == {1'b0, ni}) begin
            i_ff <= '0;
            j_ff <= j_ff + DIM_W'(1);
         end else begin
            i_ff <= i_ff + DIM_W'(1);
         end
      end
      if (cmd.calc) begin
         faddr_ff <= {dy[ROW_BITS-1:0], dx[COL_BITS-1:0]};
         saddr_ff <= {csy[ROW_BITS-1:0], csx[COL_BITS-1:0]};
         fok_ff   <= fok;
         sok_ff   <= sok;
      end
      if (cmd.wr && rsp_load) begin
         rsp_pixel_ff <= fok_ff ? f_rd : '0;
      end
   end

   assign status.func       = func_ff;
   assign status.clear_last = (clr_ff == '1);
   assign status.loop_empty = (ni == '0) || (nj == '0);
   assign status.loop_last  = ({1'b0, i_ff} + 10'd1 == {1'b0, ni}) &&
                              ({1'b0, j_ff} + 10'd1 == {1'b0, nj});
   assign status.seg_last   = (func_ff != FUNC_OUTLINE) || (seg_ff == 2'd3);
   assign status.rsp_busy   = rsp_valid_ff && rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_value = rsp_pixel_ff;

endmodule
